FILE: hdl/tps_pkg.sv
// Package for the triangle plane slicer: widths, table sizing, payload
// structs, the divider cell record and the sequencer states.
// No dependencies.
package tps_pkg;

  // Field widths
  localparam int COORD_W = 32;   // Q16.16 coordinate
  localparam int NRM_W   = 16;   // Q2.14 normal component
  localparam int TOL_W   = 16;
  localparam int SUM_W   = 9;    // slice_count width

  // Signed distance in Q.30: three 48-bit products and the offset term
  localparam int DIST_W  = 49;
  localparam int DEN_W   = DIST_W + 1;
  localparam int REM_W   = DEN_W + 1;
  localparam int FRAC_W  = 33;   // Q1.32 fraction, may reach 1.0
  localparam int DIV_STEPS = FRAC_W;

  // Point table sizing
  localparam int MAX_POINTS = 256;
  localparam int PT_AW  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PT_W   = 3 * COORD_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NX  = 3'd0,
    CFG_NY  = 3'd1,
    CFG_NZ  = 3'd2,
    CFG_OFF = 3'd3,
    CFG_TOL = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    FUNC_TRI = 1'b0,
    FUNC_END = 1'b1
  } func_e;

  typedef enum logic {
    KIND_POINT   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIST,
    ST_FEED,
    ST_COLLECT,
    ST_EDGE,
    ST_LERP,
    ST_SCAN,
    ST_PUSH,
    ST_FLUSH
  } state_e;

  // One restoring-division step record, handed from cell to cell
  typedef struct packed {
    logic              v;
    logic [REM_W-1:0]  r;
    logic [DEN_W-1:0]  den;
    logic [FRAC_W-1:0] q;
  } div_t;

  // Result record held in the output register
  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [SUM_W-1:0]          cnt;
    logic                      dropped;
    logic                      last;
  } res_t;

endpackage

FILE: hdl/tps_if.sv
// Channel interfaces of the triangle plane slicer: triangle input and
// result output, each with valid, ready and payload. Uses tps_pkg.
interface tps_in_if import tps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [COORD_W-1:0] a_x;
  logic signed [COORD_W-1:0] a_y;
  logic signed [COORD_W-1:0] a_z;
  logic signed [COORD_W-1:0] b_x;
  logic signed [COORD_W-1:0] b_y;
  logic signed [COORD_W-1:0] b_z;
  logic signed [COORD_W-1:0] c_x;
  logic signed [COORD_W-1:0] c_y;
  logic signed [COORD_W-1:0] c_z;

  modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink   (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface tps_out_if import tps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic [SUM_W-1:0]          slice_count;
  logic                      dropped;
  logic                      last;

  modport source (output valid, kind, point_x, point_y, point_z, slice_count,
                  dropped, last, input ready);
  modport sink   (input valid, kind, point_x, point_y, point_z, slice_count,
                  dropped, last, output ready);
endinterface

FILE: hdl/tps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tps_div_cell.sv
// One restoring-division step: compare, subtract, shift; registered.
// Uses tps_pkg.
module tps_div_cell import tps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  div_t cell_i,
  output div_t cell_o
);

  logic             ge;
  logic [REM_W-1:0] rem;
  logic             v_q;
  div_t             pay_q;

  // Quotient bit and partial remainder
  always_comb begin
    ge  = cell_i.r >= {1'b0, cell_i.den};
    rem = ge ? cell_i.r - {1'b0, cell_i.den} : cell_i.r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= cell_i.v;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q.v   <= 1'b0;
    pay_q.r   <= {rem[REM_W-2:0], 1'b0};
    pay_q.den <= cell_i.den;
    pay_q.q   <= {cell_i.q[FRAC_W-2:0], ge};
  end

  always_comb begin
    cell_o   = pay_q;
    cell_o.v = v_q;
  end

endmodule

FILE: hdl/tps_div_chain.sv
// Row of division cells: one quotient bit per cell, a new operand pair
// may enter every cycle. Uses tps_pkg and tps_div_cell.
module tps_div_chain import tps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  div_t div_i,
  output div_t div_o
);

  div_t link [DIV_STEPS+1];

  assign link[0] = div_i;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    tps_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[g]),
      .cell_o (link[g+1])
    );
  end

  assign div_o = link[DIV_STEPS];

endmodule

FILE: hdl/triangle_plane_slicer.sv
// Triangle plane slicer top level: distances, divider chain, interpolation,
// duplicate scan over the point table and result ordering.
// Per triangle: the distances and the 33-cell divider chain, then per crossing
// edge the interpolation, a scan of the N points stored in this slice (one
// entry a cycle) and, when an earlier point is held, its hand-on. One item at
// a time.
// Reset clears configuration to defaults, point count and drop flag; the
// table needs no clearing pass.
module triangle_plane_slicer import tps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tps_in_if.sink                in_i,
  tps_out_if.source             out_o
);

  // Configuration registers
  logic signed [NRM_W-1:0]   nx_q, ny_q, nz_q;
  logic signed [COORD_W-1:0] off_q;
  logic [TOL_W-1:0]          tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q  <= '0;
      ny_q  <= NRM_W'(16384);
      nz_q  <= '0;
      off_q <= '0;
      tol_q <= TOL_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NX:  nx_q  <= cfg_data_i[NRM_W-1:0];
        CFG_NY:  ny_q  <= cfg_data_i[NRM_W-1:0];
        CFG_NZ:  nz_q  <= cfg_data_i[NRM_W-1:0];
        CFG_OFF: off_q <= cfg_data_i[COORD_W-1:0];
        CFG_TOL: tol_q <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer registers
  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             held_v_q, held_v_d;
  logic             out_v_q, out_v_d;
  logic [1:0]       vi_q, vi_d, ax_q, ax_d;
  logic             iss_done_q, iss_done_d;
  logic             pv_q, pv_d;
  logic [1:0]       pvi_q, pvi_d, pax_q, pax_d;
  logic [1:0]       fe_q, fe_d, oc_q, oc_d, e_q, e_d, lc_q, lc_d;
  logic             lag_v_q, lag_v_d;
  logic [1:0]       lag_c_q, lag_c_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;

  // Datapath registers
  logic signed [COORD_W-1:0] v_q [3][3];
  logic signed [DIST_W-1:0]  d_q [3];
  logic signed [DIST_W-1:0]  prod_q, prod_d, acc_q, acc_d;
  logic [2:0]                cross_q, cross_d, denz_q, denz_d;
  logic [FRAC_W-1:0]         s_q [3];
  logic [DEN_W-1:0]          hi_q, hi_d;
  logic [DEN_W-2:0]          lo_q, lo_d;
  logic                      neg_q, neg_d;
  logic signed [COORD_W-1:0] lp_q, lp_d;
  logic signed [COORD_W-1:0] pt_q [3];
  res_t                      held_q, held_d, out_q, out_d;

  logic in_take;
  logic out_free;
  logic wr_v, wr_d, wr_s, wr_pt;
  logic [1:0] wr_idx;
  logic signed [DIST_W-1:0] wr_val;
  logic signed [COORD_W-1:0] pt_val;

  div_t div_in, div_out;
  logic ram_we;
  logic [PT_W-1:0] ram_rdata;
  logic [PT_AW-1:0] ram_raddr;

  assign out_free = !out_v_q || out_o.ready;

  // Next vertex of an edge
  function automatic logic [1:0] next_vtx(input logic [1:0] e);
    next_vtx = (e == 2'd2) ? 2'd0 : e + 2'd1;
  endfunction

  // Offset term in Q.30
  logic signed [DIST_W-1:0] off_term;
  assign off_term = {{(DIST_W-COORD_W-14){off_q[COORD_W-1]}}, off_q, 14'b0};

  // Distance product select
  logic signed [NRM_W-1:0]   nsel;
  logic signed [COORD_W-1:0] vsel;
  always_comb begin
    case (ax_q)
      2'd0:    nsel = nx_q;
      2'd1:    nsel = ny_q;
      default: nsel = nz_q;
    endcase
    vsel = v_q[vi_q][ax_q];
  end

  // Feed operands for edge fe_q
  logic signed [DIST_W-1:0] dp, dq;
  logic [DIST_W-1:0]        ap, aq;
  logic [DEN_W-1:0]         den;
  always_comb begin
    dp  = d_q[fe_q];
    dq  = d_q[next_vtx(fe_q)];
    ap  = dp[DIST_W-1] ? DIST_W'(-dp) : DIST_W'(dp);
    aq  = dq[DIST_W-1] ? DIST_W'(-dq) : DIST_W'(dq);
    den = {1'b0, ap} + {1'b0, aq};
  end

  // Interpolation multiply for coordinate lc_q of edge e_q
  logic signed [COORD_W-1:0] lpv, lqv;
  logic signed [COORD_W:0]   ldiff;
  logic [COORD_W:0]          lmag;
  logic [FRAC_W-1:0]         ls;
  always_comb begin
    lpv   = v_q[e_q][lc_q];
    lqv   = v_q[next_vtx(e_q)][lc_q];
    ldiff = {lqv[COORD_W-1], lqv} - {lpv[COORD_W-1], lpv};
    lmag  = ldiff[COORD_W] ? (COORD_W+1)'(-ldiff) : ldiff;
    ls    = s_q[e_q];
  end

  // Interpolation sum
  logic [DEN_W:0]     lsum;
  logic [COORD_W:0]   lt;
  logic [COORD_W+1:0] lres;
  always_comb begin
    lsum = {1'b0, hi_q} + {{18{1'b0}}, lo_q[DEN_W-2:16]};
    lt   = lsum[16 +: (COORD_W+1)];
    lres = neg_q ? {{2{lp_q[COORD_W-1]}}, lp_q} - {1'b0, lt}
                 : {{2{lp_q[COORD_W-1]}}, lp_q} + {1'b0, lt};
    pt_val = lres[COORD_W-1:0];
  end

  // Duplicate test against the entry read back
  logic signed [COORD_W-1:0] ent [3];
  logic [2:0]                ax_hit;
  logic                      match;
  always_comb begin
    ent[0] = ram_rdata[0 +: COORD_W];
    ent[1] = ram_rdata[COORD_W +: COORD_W];
    ent[2] = ram_rdata[2*COORD_W +: COORD_W];
    for (int k = 0; k < 3; k++) begin
      logic signed [COORD_W:0] df;
      logic [COORD_W:0]        mg;
      df = {ent[k][COORD_W-1], ent[k]} - {pt_q[k][COORD_W-1], pt_q[k]};
      mg = df[COORD_W] ? (COORD_W+1)'(-df) : df;
      ax_hit[k] = mg < {{(COORD_W+1-TOL_W){1'b0}}, tol_q};
    end
    match = &ax_hit;
  end

  // Saturated count for the summary
  logic [31:0] cnt_ext;
  logic        full;
  assign cnt_ext = 32'(cnt_q);
  assign full    = cnt_ext >= 32'(MAX_POINTS);

  // Next state and control
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    held_v_d   = held_v_q;
    held_d     = held_q;
    out_v_d    = out_v_q && !out_o.ready;
    out_d      = out_q;
    vi_d       = vi_q;
    ax_d       = ax_q;
    iss_done_d = iss_done_q;
    pv_d       = 1'b0;
    pvi_d      = vi_q;
    pax_d      = ax_q;
    prod_d     = prod_q;
    acc_d      = acc_q;
    fe_d       = fe_q;
    oc_d       = oc_q;
    e_d        = e_q;
    lc_d       = lc_q;
    lag_v_d    = 1'b0;
    lag_c_d    = lc_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    neg_d      = neg_q;
    lp_d       = lp_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    cross_d    = cross_q;
    denz_d     = denz_q;
    in_take    = 1'b0;
    wr_v       = 1'b0;
    wr_d       = 1'b0;
    wr_s       = 1'b0;
    wr_pt      = 1'b0;
    wr_idx     = 2'd0;
    wr_val     = acc_q;
    div_in     = '0;
    ram_we     = 1'b0;
    ram_raddr  = idx_q[PT_AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        in_take = 1'b1;
        if (in_i.valid) begin
          if (in_i.func == FUNC_END) begin
            state_d = ST_SUM;
          end else begin
            wr_v       = 1'b1;
            vi_d       = 2'd0;
            ax_d       = 2'd0;
            iss_done_d = 1'b0;
            state_d    = ST_DIST;
          end
        end
      end

      // Summary result, then the slice starts over
      ST_SUM: begin
        if (out_free) begin
          out_v_d     = 1'b1;
          out_d       = '0;
          out_d.kind  = KIND_SUMMARY;
          out_d.cnt   = (cnt_ext > 32'd511) ? SUM_W'(511) : cnt_ext[SUM_W-1:0];
          out_d.dropped = ovf_q;
          out_d.last  = 1'b1;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      // One product a cycle, accumulated in the next
      ST_DIST: begin
        if (!iss_done_q) begin
          prod_d = nsel * vsel;
          pv_d   = 1'b1;
          if (ax_q == 2'd2) begin
            ax_d = 2'd0;
            vi_d = vi_q + 2'd1;
            if (vi_q == 2'd2) begin
              iss_done_d = 1'b1;
            end
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end
        if (pv_q) begin
          acc_d = (pax_q == 2'd0) ? prod_q - off_term : acc_q + prod_q;
          if (pax_q == 2'd2) begin
            wr_d   = 1'b1;
            wr_idx = pvi_q;
            wr_val = acc_q + prod_q;
            if (pvi_q == 2'd2) begin
              fe_d    = 2'd0;
              state_d = ST_FEED;
            end
          end
        end
      end

      // Push every edge of the triangle into the divider chain
      ST_FEED: begin
        div_in.v   = 1'b1;
        div_in.r   = {2'b0, ap};
        div_in.den = den;
        div_in.q   = '0;
        cross_d[fe_q] = (dp <= 0 && dq >= 0) || (dp >= 0 && dq <= 0);
        denz_d[fe_q]  = (den == '0);
        fe_d = fe_q + 2'd1;
        if (fe_q == 2'd2) begin
          oc_d    = 2'd0;
          state_d = ST_COLLECT;
        end
      end

      ST_COLLECT: begin
        if (div_out.v) begin
          wr_s   = 1'b1;
          wr_idx = oc_q;
          oc_d   = oc_q + 2'd1;
          if (oc_q == 2'd2) begin
            e_d     = 2'd0;
            state_d = ST_EDGE;
          end
        end
      end

      ST_EDGE: begin
        if (e_q == 2'd3) begin
          state_d = ST_FLUSH;
        end else if (!cross_q[e_q]) begin
          e_d = e_q + 2'd1;
        end else begin
          lc_d    = 2'd0;
          state_d = ST_LERP;
        end
      end

      // One coordinate a cycle: multiply, then add on the next
      ST_LERP: begin
        if (lc_q != 2'd3) begin
          hi_d    = DEN_W'(lmag * ls[FRAC_W-1:16]);
          lo_d    = (DEN_W-1)'(lmag * ls[15:0]);
          neg_d   = ldiff[COORD_W];
          lp_d    = lpv;
          lag_v_d = 1'b1;
          lc_d    = lc_q + 2'd1;
        end
        if (lag_v_q) begin
          wr_pt  = 1'b1;
          wr_idx = lag_c_q;
          if (lag_c_q == 2'd2) begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end

      // Stream stored points past the new one
      ST_SCAN: begin
        if (idx_q < cnt_q) begin
          idx_d  = idx_q + CNT_W'(1);
          pend_d = 1'b1;
        end
        if (pend_q && match) begin
          pend_d  = 1'b0;
          e_d     = e_q + 2'd1;
          state_d = ST_EDGE;
        end else if (!(idx_q < cnt_q) && !pend_q) begin
          if (full) begin
            ovf_d   = 1'b1;
            e_d     = e_q + 2'd1;
            state_d = ST_EDGE;
          end else begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
            if (held_v_q) begin
              state_d = ST_PUSH;
            end else begin
              held_v_d = 1'b1;
              held_d   = '0;
              held_d.x = pt_q[0];
              held_d.y = pt_q[1];
              held_d.z = pt_q[2];
              e_d      = e_q + 2'd1;
              state_d  = ST_EDGE;
            end
          end
        end
      end

      // Older held point goes out, the new one waits for its last flag
      ST_PUSH: begin
        if (out_free) begin
          out_v_d  = 1'b1;
          out_d    = held_q;
          held_d   = '0;
          held_d.x = pt_q[0];
          held_d.y = pt_q[1];
          held_d.z = pt_q[2];
          e_d      = e_q + 2'd1;
          state_d  = ST_EDGE;
        end
      end

      ST_FLUSH: begin
        if (!held_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d     = 1'b1;
          out_d       = held_q;
          out_d.last  = 1'b1;
          held_v_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      held_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      vi_q       <= '0;
      ax_q       <= '0;
      iss_done_q <= 1'b0;
      pv_q       <= 1'b0;
      pvi_q      <= '0;
      pax_q      <= '0;
      fe_q       <= '0;
      oc_q       <= '0;
      e_q        <= '0;
      lc_q       <= '0;
      lag_v_q    <= 1'b0;
      lag_c_q    <= '0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      held_v_q   <= held_v_d;
      out_v_q    <= out_v_d;
      vi_q       <= vi_d;
      ax_q       <= ax_d;
      iss_done_q <= iss_done_d;
      pv_q       <= pv_d;
      pvi_q      <= pvi_d;
      pax_q      <= pax_d;
      fe_q       <= fe_d;
      oc_q       <= oc_d;
      e_q        <= e_d;
      lc_q       <= lc_d;
      lag_v_q    <= lag_v_d;
      lag_c_q    <= lag_c_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    cross_q <= cross_d;
    denz_q  <= denz_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    neg_q   <= neg_d;
    lp_q    <= lp_d;
    held_q  <= held_d;
    out_q   <= out_d;
    if (wr_v) begin
      v_q[0][0] <= in_i.a_x;
      v_q[0][1] <= in_i.a_y;
      v_q[0][2] <= in_i.a_z;
      v_q[1][0] <= in_i.b_x;
      v_q[1][1] <= in_i.b_y;
      v_q[1][2] <= in_i.b_z;
      v_q[2][0] <= in_i.c_x;
      v_q[2][1] <= in_i.c_y;
      v_q[2][2] <= in_i.c_z;
    end
    if (wr_d) begin
      d_q[wr_idx] <= wr_val;
    end
    if (wr_s) begin
      s_q[wr_idx] <= denz_q[wr_idx] ? '0 : div_out.q;
    end
    if (wr_pt) begin
      pt_q[wr_idx] <= pt_val;
    end
  end

  tps_div_chain u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .div_i  (div_in),
    .div_o  (div_out)
  );

  tps_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[PT_AW-1:0]),
    .wdata_i ({pt_q[2], pt_q[1], pt_q[0]}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Ports
  assign in_i.ready        = in_take;
  assign out_o.valid       = out_v_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.point_x     = out_q.x;
  assign out_o.point_y     = out_q.y;
  assign out_o.point_z     = out_q.z;
  assign out_o.slice_count = out_q.cnt;
  assign out_o.dropped     = out_q.dropped;
  assign out_o.last        = out_q.last;

endmodule

FILE: verif/tb_triangle_plane_slicer.sv
// Self-checking testbench for triangle_plane_slicer: random and directed triangles,
// slice ends and register writes, checked against an in-bench slicing model.
// Depends on tps_pkg, tps_in_if/tps_out_if and the triangle_plane_slicer RTL.
module tb_triangle_plane_slicer;
  import tps_pkg::*;

  // Slicing model: plane registers, point table and the expected results queue
  class slice_scoreboard;
    longint nrm[3];
    longint offset;
    longint tol;
    longint pts[MAX_POINTS][3];
    int     npts;
    bit     overflow;
    res_t   expected_q[$];
    int     errors;

    function new();
      nrm = '{0, 16384, 0};
      offset = 0;
      tol = 1;
      npts = 0;
      overflow = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        CFG_NX:  nrm[0] = longint'($signed(val[15:0]));
        CFG_NY:  nrm[1] = longint'($signed(val[15:0]));
        CFG_NZ:  nrm[2] = longint'($signed(val[15:0]));
        CFG_OFF: offset = longint'($signed(val));
        CFG_TOL: tol = longint'(val[15:0]);
        default: ;
      endcase
    endfunction

    // Signed distance in Q.30
    function longint plane_dist(longint v[3]);
      return nrm[0] * v[0] + nrm[1] * v[1] + nrm[2] * v[2] - offset * 16384;
    endfunction

    // Truncated Q1.32 fraction num/den, num <= den
    function longint unsigned fraction(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = 0;
      r = num;
      if (den == 0) return 0;
      if (r >= den) begin
        q = 1;
        r -= den;
      end
      for (int i = 0; i < 32; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r -= den;
          q |= 1;
        end
      end
      return q;
    endfunction

    function longint interp(longint p, longint q, longint unsigned s);
      longint d, t;
      longint unsigned m, hi, lo;
      d = q - p;
      m = (d < 0) ? -d : d;
      hi = m * (s >> 16);
      lo = m * (s & 64'hFFFF);
      t = longint'((hi + (lo >> 16)) >> 16);
      return (d < 0) ? p - t : p + t;
    endfunction

    function bit is_dup(longint pt[3]);
      longint d;
      bit same;
      for (int i = 0; i < npts; i++) begin
        same = 1;
        for (int k = 0; k < 3; k++) begin
          d = pts[i][k] - pt[k];
          if (d < 0) d = -d;
          if (d >= tol) same = 0;
        end
        if (same) return 1;
      end
      return 0;
    endfunction

    function void cross_edge(longint p[3], longint q[3], longint dp, longint dq);
      longint unsigned ap, aq, s;
      longint pt[3];
      res_t r;
      if (!((dp <= 0 && dq >= 0) || (dp >= 0 && dq <= 0))) return;
      ap = (dp < 0) ? -dp : dp;
      aq = (dq < 0) ? -dq : dq;
      s = fraction(ap, ap + aq);
      for (int k = 0; k < 3; k++) pt[k] = interp(p[k], q[k], s);
      if (is_dup(pt)) return;
      if (npts >= MAX_POINTS) begin
        overflow = 1;
        return;
      end
      pts[npts] = pt;
      npts++;
      r = '0;
      r.kind = KIND_POINT;
      r.x = pt[0][31:0];
      r.y = pt[1][31:0];
      r.z = pt[2][31:0];
      expected_q.push_back(r);
    endfunction

    // Accepted input transfer: append the results it causes
    function void note_input(func_e fn, logic signed [31:0] c[9]);
      longint v[3][3];
      longint d[3];
      int n_prev;
      res_t r;
      if (fn == FUNC_END) begin
        r = '0;
        r.kind = KIND_SUMMARY;
        r.cnt = (npts > 511) ? SUM_W'(511) : SUM_W'(npts);
        r.dropped = overflow;
        r.last = 1;
        expected_q.push_back(r);
        npts = 0;
        overflow = 0;
        return;
      end
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) v[i][k] = longint'(c[i * 3 + k]);
        d[i] = plane_dist(v[i]);
      end
      n_prev = expected_q.size();
      cross_edge(v[0], v[1], d[0], d[1]);
      cross_edge(v[1], v[2], d[1], d[2]);
      cross_edge(v[2], v[0], d[2], d[0]);
      if (expected_q.size() > n_prev) expected_q[$].last = 1;
    endfunction

    function void field(string name, longint e, longint g);
      if (e != g) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, e, g);
      end
    endfunction

    // Accepted result transfer: compare with the oldest expectation
    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got %p", $time, got);
        return;
      end
      e = expected_q.pop_front();
      field("kind", e.kind, got.kind);
      field("point_x", e.x, got.x);
      field("point_y", e.y, got.y);
      field("point_z", e.z, got.z);
      field("slice_count", e.cnt, got.cnt);
      field("dropped", e.dropped, got.dropped);
      field("last", e.last, got.last);
    endfunction
  endclass

  localparam int DRAIN_WAIT = 1200;
  localparam int STALL_LIMIT = 20000;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  tps_in_if  in_if();
  tps_out_if out_if();

  triangle_plane_slicer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  slice_scoreboard sb = new();
  logic signed [31:0] vpool[8][3];
  bit  fast_mode = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 0;
    in_if.func = FUNC_TRI;
    {in_if.a_x, in_if.a_y, in_if.a_z, in_if.b_x, in_if.b_y, in_if.b_z} = '0;
    {in_if.c_x, in_if.c_y, in_if.c_z} = '0;
    out_if.ready = 0;
  end

  // Result side: random ready with one long hold-off
  initial begin
    bit held;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 30) begin
        held = 1;
        out_if.ready = 0;
        repeat (400) @(negedge clk_i);
      end else if (fast_mode) begin
        out_if.ready = 1;
      end else begin
        out_if.ready = ($urandom_range(99) < 70) || ($urandom_range(99) < 5);
        if ($urandom_range(99) < 3) begin
          out_if.ready = 0;
          repeat ($urandom_range(10, 40)) @(negedge clk_i);
        end
      end
    end
  end

  // Result check and watchdog on every rising edge
  always @(posedge clk_i) begin
    res_t got;
    if (out_if.valid && out_if.ready) begin
      got.kind = out_if.kind;
      got.x = out_if.point_x;
      got.y = out_if.point_y;
      got.z = out_if.point_z;
      got.cnt = out_if.slice_count;
      got.dropped = out_if.dropped;
      got.last = out_if.last;
      sb.check_result(got);
      results_seen++;
    end
    if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) || cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_triangle_plane_slicer: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (fast_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, hold it until the transfer, then note it
  task automatic send_item(func_e fn, logic signed [31:0] c[9]);
    repeat (pick_gap()) begin
      in_if.valid = 0;
      @(negedge clk_i);
    end
    in_if.valid = 1;
    in_if.func = fn;
    {in_if.a_x, in_if.a_y, in_if.a_z} = {c[0], c[1], c[2]};
    {in_if.b_x, in_if.b_y, in_if.b_z} = {c[3], c[4], c[5]};
    {in_if.c_x, in_if.c_y, in_if.c_z} = {c[6], c[7], c[8]};
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_input(fn, c);
    @(negedge clk_i);
    in_if.valid = 0;
  endtask

  task automatic drain();
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_plane(int nx, int ny, int nz, int off, int tol);
    write_reg(CFG_NX, nx);
    write_reg(CFG_NY, ny);
    write_reg(CFG_NZ, nz);
    write_reg(CFG_OFF, off);
    write_reg(CFG_TOL, tol);
  endtask

  task automatic send_tri(logic signed [31:0] a[3], logic signed [31:0] b[3],
                          logic signed [31:0] c[3]);
    logic signed [31:0] v[9];
    v = '{a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]};
    send_item(FUNC_TRI, v);
  endtask

  task automatic end_slice();
    logic signed [31:0] v[9];
    foreach (v[i]) v[i] = $urandom;
    send_item(FUNC_END, v);
  endtask

  function automatic logic signed [31:0] near();
    return int'($urandom_range(2097152)) - 1048576;
  endfunction

  // Mostly mesh-like triangles from a shared vertex pool, some full-range noise
  task automatic random_items(int count);
    logic signed [31:0] v[9];
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 3) foreach (vpool[i, k]) vpool[i][k] = near();
      if (r < 8) begin
        end_slice();
      end else if (r < 22) begin
        foreach (v[i]) v[i] = $urandom;
        send_item(FUNC_TRI, v);
      end else begin
        send_tri(vpool[$urandom_range(7)], vpool[$urandom_range(7)],
                 vpool[$urandom_range(7)]);
      end
    end
  endtask

  function automatic int rnd_nrm();
    return int'($urandom_range(32768)) - 16384;
  endfunction

  initial begin
    logic signed [31:0] p0[3], p1[3], p2[3];
    logic signed [31:0] v[9];
    foreach (vpool[i, k]) vpool[i][k] = near();
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: default plane y = 0
    p0 = '{32'sh10000, -32'sh20000, 32'sh5}; p1 = '{-32'sh30000, 32'sh40000, 0};
    p2 = '{0, 32'sh10000, 32'sh7};
    send_tri(p0, p1, p2);
    send_tri(p0, p1, p2);                         // duplicates of stored points
    p0 = '{32'sh100, 0, 32'sh200};                // vertex on the plane
    send_tri(p0, p1, p2);
    p1 = '{-32'sh700, 0, 32'sh900};               // edge lying in the plane
    send_tri(p0, p1, p2);
    p0 = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    p1 = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    p2 = '{32'sh80000000, 32'sh7FFFFFFF, 0};
    send_tri(p0, p1, p2);                         // coordinate extremes
    p0 = '{1, 32'sh10, 1}; p1 = '{2, 32'sh20, 3}; p2 = '{4, 32'sh30, 5};
    send_tri(p0, p1, p2);                         // no crossing
    end_slice();
    end_slice();                                  // empty slice
    drain();

    // Zero normal and zero offset: every edge lies in the plane
    set_plane(0, 0, 0, 0, 65535);
    p0 = '{1, 2, 3}; p1 = '{32'sh7FFFFFFF, 5, 6}; p2 = '{-9, 32'sh80000000, 4};
    send_tri(p0, p1, p2);
    send_tri(p0, p1, p2);
    end_slice();
    drain();

    // Extreme normals and offsets, tolerance zero and then 65535
    set_plane(-16384, 16384, -16384, 32'sh7FFFFFFF, 0);
    send_tri(p0, p1, p2);
    for (int i = 0; i < 4; i++) begin
      foreach (v[j]) v[j] = $urandom;
      send_item(FUNC_TRI, v);
    end
    end_slice();
    drain();
    set_plane(16384, -16384, 16384, 32'sh80000000, 65535);
    send_tri(p0, p1, p2);
    end_slice();
    drain();

    // Fill the table past its size with distinct points
    set_plane(0, 16384, 0, 0, 0);
    fast_mode = 1;
    for (int i = 0; i < 160; i++) begin
      p0 = '{near(), int'($urandom_range(1, 1048576)), near()};
      p1 = '{near(), -int'($urandom_range(1, 1048576)), near()};
      p2 = '{near(), near(), near()};
      send_tri(p0, p1, p2);
    end
    end_slice();
    fast_mode = 0;
    drain();

    // Random phases with varied planes and tolerances
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_plane(0, 16384, 0, 0, 1);
        1: set_plane(16384, 0, 0, int'($urandom_range(65536)) - 32768, 4);
        2: set_plane(rnd_nrm(), rnd_nrm(), rnd_nrm(),
                     int'($urandom_range(131072)) - 65536, $urandom_range(65535));
        3: set_plane(0, 0, -16384, 0, $urandom_range(16));
        default: set_plane(rnd_nrm(), rnd_nrm(), rnd_nrm(), 0, 0);
      endcase
      fast_mode = (ph == 3);
      random_items(50);
      end_slice();
      drain();
    end

    fast_mode = 0;
    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("tb_triangle_plane_slicer: PASS");
    else
      $display("tb_triangle_plane_slicer: FAIL");
    $finish;
  end

endmodule

FILE: files.f
hdl/tps_pkg.sv
hdl/tps_if.sv
hdl/tps_ram.sv
hdl/tps_div_cell.sv
hdl/tps_div_chain.sv
hdl/triangle_plane_slicer.sv
verif/tb_triangle_plane_slicer.sv
